// ----- hdl/sha256_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Payload types, initial hash values, round constants and round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [3:0]  valid_nibbles;
    logic        last_word;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_done;
  } sha_out_t;

  // Word class handed from the front part to the back part.
  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_LAST = 2'd1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] word;
    logic [3:0]  nib;
  } sha_cmd_t;

  localparam logic [31:0] PAD_ONE = 32'h8000_0000;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sha256_front.sv -----
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts message words, classifies them and pushes commands into a queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_front
  import sha256_pkg::*;
#(
  parameter int DEPTH_LOG2 = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire sha_in_t  in_data,
  output logic          cmd_valid,
  input  wire logic     cmd_ready,
  output sha_cmd_t      cmd_data
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  sha_cmd_t               q_mem [DEPTH];
  logic [DEPTH_LOG2-1:0]  wr_ptr_r, rd_ptr_r;
  logic [DEPTH_LOG2:0]    cnt_r, cnt_nxt;
  sha_cmd_t               new_cmd;
  logic                   push, pop;

  assign in_ready  = (cnt_r != (DEPTH_LOG2+1)'(DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd_data  = q_mem[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    new_cmd.word = in_data.data_word;
    if (in_data.last_word) begin
      new_cmd.cmd = CMD_LAST;
      new_cmd.nib = (in_data.valid_nibbles > 4'd8) ? 4'd8 : in_data.valid_nibbles;
    end else begin
      new_cmd.cmd = CMD_DATA;
      new_cmd.nib = 4'd8;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sha256_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 back end
// Loads words into the block, pads, runs one round per cycle and emits digest.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_core
  import sha256_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cmd_valid,
  output logic          cmd_ready,
  input  wire sha_cmd_t cmd_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output sha_out_t      out_data
);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state_r;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [3:0]  wib_r;
  logic [63:0] len_r;
  logic [5:0]  rnd_r;
  logic        pad_r;
  logic        fin_r;
  logic        skip_len_r;
  logic [1:0]  len_step_r;
  logic [2:0]  oidx_r;

  logic [31:0] wsel, wnew, t1, t2, in_word, pad_word, mask;
  logic [4:0]  shamt;
  logic        take;

  assign cmd_ready = (state_r == ST_LOAD);
  assign take      = cmd_valid && cmd_ready;
  assign out_valid = (state_r == ST_OUT);
  assign out_data.digest_word  = h_r[oidx_r];
  assign out_data.digest_index = oidx_r;
  assign out_data.digest_done  = (oidx_r == 3'd7);

  always_comb begin
    shamt = 5'(31 - 4 * cmd_data.nib);
    if (cmd_data.nib == 4'd0) begin
      mask = '0;
    end else begin
      mask = 32'hFFFF_FFFF << 6'(32 - 4 * cmd_data.nib);
    end
    if (cmd_data.cmd == CMD_LAST && cmd_data.nib != 4'd8) begin
      in_word = (cmd_data.word & mask) | (32'd1 << shamt);
    end else begin
      in_word = cmd_data.word;
    end
    if (pad_r) begin
      pad_word = PAD_ONE;
    end else if (skip_len_r) begin
      pad_word = '0;
    end else if (wib_r == 4'd14) begin
      pad_word = len_r[63:32];
    end else if (wib_r == 4'd15) begin
      pad_word = len_r[31:0];
    end else begin
      pad_word = '0;
    end
  end

  // Schedule: window slot rnd[3:0] is rewritten in place once rnd >= 16.
  always_comb begin
    wnew = ssig1(w_r[4'(rnd_r - 6'd2)]) + w_r[4'(rnd_r - 6'd7)]
         + ssig0(w_r[4'(rnd_r - 6'd15)]) + w_r[rnd_r[3:0]];
    wsel = (rnd_r < 6'd16) ? w_r[rnd_r[3:0]] : wnew;
    t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + ROUND_K[rnd_r] + wsel;
    t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      wib_r   <= '0;
      len_r   <= '0;
      rnd_r   <= '0;
      pad_r   <= 1'b0;
      fin_r   <= 1'b0;
      skip_len_r <= 1'b0;
      len_step_r <= '0;
      oidx_r  <= '0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= iv_word(3'(i));
      end
    end else begin
      case (state_r)
        ST_LOAD: begin
          if (take) begin
            w_r[wib_r] <= in_word;
            wib_r      <= wib_r + 1'b1;
            len_r      <= len_r + 64'(4 * cmd_data.nib);
            if (cmd_data.cmd == CMD_LAST) begin
              fin_r <= 1'b1;
              pad_r <= (cmd_data.nib == 4'd8);
              skip_len_r <= (cmd_data.nib != 4'd8) && (wib_r == 4'd14);
              state_r <= (wib_r == 4'd15) ? ST_RUN : ST_PAD;
            end else if (wib_r == 4'd15) begin
              state_r <= ST_RUN;
            end
            if (wib_r == 4'd15) begin
              for (int i = 0; i < 8; i++) begin
                v_r[i] <= h_r[i];
              end
            end
          end
        end
        ST_PAD: begin
          // Words 14 and 15 take the length only when the one-bit word sits
          // below word 14 of this block or in an earlier block.
          w_r[wib_r] <= pad_word;
          pad_r      <= 1'b0;
          wib_r      <= wib_r + 1'b1;
          if (pad_r && wib_r == 4'd14) begin
            skip_len_r <= 1'b1;
          end
          if (!pad_r && !skip_len_r && wib_r == 4'd15) begin
            len_step_r <= 2'd1;
          end
          if (wib_r == 4'd15) begin
            state_r <= ST_RUN;
            for (int i = 0; i < 8; i++) begin
              v_r[i] <= h_r[i];
            end
          end else if (!pad_r && wib_r == 4'd14) begin
            state_r <= ST_PAD;
          end
        end
        ST_RUN: begin
          if (rnd_r >= 6'd16) begin
            w_r[rnd_r[3:0]] <= wnew;
          end
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 1'b1;
          if (rnd_r == 6'd63) begin
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= h_r[i] + v_r[i];
          end
          skip_len_r <= 1'b0;
          if (!fin_r) begin
            state_r <= ST_LOAD;
          end else if (len_step_r == 2'd1) begin
            state_r <= ST_OUT;
          end else begin
            state_r <= ST_PAD;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            oidx_r <= oidx_r + 1'b1;
            if (oidx_r == 3'd7) begin
              state_r    <= ST_LOAD;
              wib_r      <= '0;
              len_r      <= '0;
              fin_r      <= 1'b0;
              len_step_r <= '0;
              for (int i = 0; i < 8; i++) begin
                h_r[i] <= iv_word(3'(i));
              end
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sha256_hash_engine_top.sv -----
// ----------------------------------------------------------------------------
// SHA-256 hash engine top level
// Message words in, eight digest words out.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one 32-bit big-endian message word per
// transaction with a nibble count and a last flag. A small queue decouples
// the input side from the compression core, so words are taken while the
// core is busy until the queue fills. Each block of 16 words is loaded,
// run through 64 rounds by the single round unit and added into the hash.
// The last word triggers padding, one or two final compressions and then
// eight result transactions, index 0 first, with done set on index 7. When
// the receiver stalls, the current digest word is held and the core waits;
// the input queue keeps filling. Reset restores the initial hash values
// and clears the length and all control state. After the digest the engine
// is ready for the next message.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_hash_engine_top
  import sha256_pkg::*;
#(
  parameter int QUEUE_LOG2 = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire sha_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output sha_out_t      out_data
);

  logic     cmd_valid, cmd_ready;
  sha_cmd_t cmd_data;

  sha256_front #(.DEPTH_LOG2(QUEUE_LOG2)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cmd_valid, .cmd_ready, .cmd_data
  );

  sha256_core u_core (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd_data,
    .out_valid, .out_ready, .out_data
  );

endmodule

`default_nettype wire

// ----- hdl/sha256_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-256 engine port checker
// Watches the top-level result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_checker
  import sha256_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire sha_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.digest_done |=>
      out_valid && out_data.digest_index == $past(out_data.digest_index) + 3'd1)
    else $error("digest words not consecutive");

  a_done_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.digest_done == (out_data.digest_index == 3'd7)))
    else $error("done flag misplaced");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind sha256_hash_engine_top sha256_checker u_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_data
);

`default_nettype wire

// ----- dv/sha256_digest_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both channels of the hash engine, computes the expected digest of
// each message on its own and compares every digest word field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_digest_checker
  import sha256_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_ready,
  input  wire sha_in_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_ready,
  input  wire sha_out_t out_data,
  output int            fail_count,
  output int            pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0] hash_state [8];
  logic [31:0] block_buf [16];
  logic [3:0]  block_fill;
  logic [63:0] msg_bits;
  sha_out_t    digest_q [$];

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic run_rounds();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = block_buf[i];
    for (int i = 16; i < 64; i++)
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
             (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) +
           K_TAB[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic append_word(logic [31:0] w);
    block_buf[block_fill] = w;
    block_fill = block_fill + 4'd1;
    if (block_fill == 4'd0) run_rounds();
  endtask

  task automatic clear_message();
    for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
    for (int i = 0; i < 16; i++) block_buf[i] = '0;
    block_fill = '0;
    msg_bits = '0;
  endtask

  task automatic absorb_word(sha_in_t t);
    logic [3:0]  nib;
    logic [31:0] mask;
    sha_out_t    d;
    if (!t.last_word) begin
      msg_bits += 64'd32;
      append_word(t.data_word);
      return;
    end
    nib = (t.valid_nibbles > 4'd8) ? 4'd8 : t.valid_nibbles;
    msg_bits += 64'(4 * nib);
    if (nib == 4'd8) begin
      append_word(t.data_word);
      append_word(32'h8000_0000);
    end else begin
      mask = (nib == 0) ? 32'h0 : (32'hffff_ffff << (32 - 4 * nib));
      append_word((t.data_word & mask) | (32'h1 << (31 - 4 * nib)));
    end
    while (block_fill != 4'd14) append_word(32'h0);
    append_word(msg_bits[63:32]);
    append_word(msg_bits[31:0]);
    for (int k = 0; k < 8; k++) begin
      d.digest_word  = hash_state[k];
      d.digest_index = 3'(k);
      d.digest_done  = (k == 7);
      digest_q.push_back(d);
    end
    clear_message();
  endtask

  initial begin
    fail_count = 0;
    pending_words = 0;
    clear_message();
  end

  always @(posedge clk) begin
    sha_out_t exp_d;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest transaction %h", $realtime, out_data);
          fail_count++;
        end else begin
          exp_d = digest_q.pop_front();
          if (out_data !== exp_d) begin
            $display("%0t: digest mismatch expected word %h index %0d done %b, got %h %0d %b",
                     $realtime, exp_d.digest_word, exp_d.digest_index, exp_d.digest_done,
                     out_data.digest_word, out_data.digest_index, out_data.digest_done);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) absorb_word(in_data);
      pending_words = digest_q.size();
    end
  end

  final begin
    if (digest_q.size() != 0) $display("%0d digest words never arrived", digest_q.size());
  end
endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Sends directed and random messages with random idling on both channels and
// lets the digest checker compare every digest word.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import sha256_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sha_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sha_out_t out_data;
  int       fail_count;
  int       pending_words;
  int       idle_cycles = 0;
  bit       calm_phase = 1'b0;
  bit       timed_out = 1'b0;

  always #1 clk = ~clk;

  sha256_hash_engine_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  sha256_digest_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver stalls come in bursts; the calm phase keeps ready high.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (calm_phase || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic send_word(logic [31:0] w, logic [3:0] nib, logic last);
    int n;
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 18);
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_word: w, valid_nibbles: nib, last_word: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(int full_words, logic [3:0] last_nib, bit rand_data);
    for (int i = 0; i < full_words; i++)
      send_word(rand_data ? $urandom() : 32'hffff_ffff, 4'($urandom_range(0, 15)), 1'b0);
    send_word(rand_data ? $urandom() : 32'hffff_ffff, last_nib, 1'b1);
  endtask

  task automatic drain_digests();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_words != 0) @(negedge clk);
  endtask

  initial begin
    int words;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Empty message, all-zero and all-one words, every nibble count, over-range
    // nibble counts, and lengths around the one- and two-block padding edges.
    send_word(32'h0, 4'd0, 1'b1);
    send_word(32'h6162_6300, 4'd6, 1'b1);
    send_message(0, 4'd15, 1'b0);
    send_word(32'h0, 4'd8, 1'b1);
    for (int n = 1; n <= 9; n++) send_message(0, 4'(n), 1'b1);
    send_message(13, 4'd8, 1'b1);
    send_message(13, 4'd7, 1'b1);
    send_message(14, 4'd0, 1'b1);
    drain_digests();
    send_message(15, 4'd8, 1'b0);
    send_message(16, 4'd3, 1'b1);
    words = 0;
    while (words < 20) begin
      if ($urandom_range(0, 9) == 0) begin
        send_message(0, 4'($urandom_range(0, 15)), 1'b1);
        words += 1;
      end else begin
        int len;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 8);
        send_message(len, 4'($urandom_range(0, 15)), 1'b1);
        words += len + 1;
      end
      if (words > 10) calm_phase = 1'b1;
    end
    drain_digests();
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- sim.f -----
hdl/sha256_pkg.sv
hdl/sha256_front.sv
hdl/sha256_core.sv
hdl/sha256_hash_engine_top.sv
hdl/sha256_checker.sv
dv/sha256_digest_checker.sv
dv/testbench.sv
